@@ hdl/tng_pkg.sv @@
package tng_pkg;

   localparam int SAMPLE_BITS_DEF = 10;

   localparam int FLOOR_W  = 10;
   localparam int OFFSET_W = 8;
   localparam int CHAN_W   = 4;
   localparam int NOTE_W   = 7;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_ADDR_W = 2;

   localparam logic [FLOOR_W-1:0]  FLOOR_RST  = 10'd0;
   localparam logic [OFFSET_W-1:0] OFFSET_RST = 8'd10;
   localparam logic [CHAN_W-1:0]   CHAN_RST   = 4'd0;
   localparam logic [NOTE_W-1:0]   NOTE_RST   = 7'd60;

   localparam int FULL_SCALE = 1014;
   localparam int VEL_W      = 7;
   localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;
   localparam logic [7:0] AT_STATUS = 8'hA0;

   // serial divider: quotient below 128, divisor below 2048
   localparam int DIV_W  = 11;
   localparam int REM_W  = 18;
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_TOP = 3'd6;

   localparam int RSP_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FLOOR  = 2'd0,
      CSR_OFFSET = 2'd1,
      CSR_CHAN   = 2'd2,
      CSR_NOTE   = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic             done;
      logic [VEL_W-1:0] quo;
   } div_sts_type;

endpackage

@@ hdl/tng_div.sv @@
module tng_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tng_pkg::DIV_W-1:0] num_in,
   input  logic [tng_pkg::DIV_W-1:0] den_in,
   output tng_pkg::div_sts_type      sts
);
   import tng_pkg::*;

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  den_ff, den_in_r;
   logic [VEL_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W:0]    trial;

   // one shared subtractor, one quotient bit per cycle
   assign trial = {1'b0, rem_ff} - ({1'b0, REM_W'(den_ff)} << step_ff);

   always_comb begin
      rem_in   = rem_ff;
      den_in_r = den_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         // 127 * num
         rem_in   = {REM_W'(num_in) << VEL_W} - REM_W'(num_in);
         den_in_r = den_in;
         quo_in   = '0;
         step_in  = STEP_TOP;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[REM_W]) begin
            rem_in = trial[REM_W-1:0];
         end
         quo_in = {quo_ff[VEL_W-2:0], ~trial[REM_W]};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in_r;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;

endmodule

@@ hdl/touch_note_gate_aftertouch.sv @@
// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tdata: sample
// rsp      out        rsp_tvalid/tready    tdata: note_active, status_byte, note_out,
//                                          pressure; tuser: pressure_valid
// csr      in         csr_we               csr_addr, csr_wdata
// a transaction is accepted only in the idle state, after the previous one is emitted;
// the 7-step restoring divider runs only when the velocity is neither zero nor saturated
// the divider shares one subtractor over all quotient bits
// synchronous active-high reset clears the note state and returns the registers to their reset values
// the result sits in an output register; a new transaction is accepted while
// it waits, and only the final write-back stalls on rsp_tready
module touch_note_gate_aftertouch #(
   parameter int SAMPLE_BITS = tng_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,  // sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // note_active, status_byte, note_out, pressure
   output logic [tng_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,  // pressure_valid
   input  logic                                csr_we,
   input  logic [tng_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [tng_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tng_pkg::*;

   localparam int NUM_W = (SAMPLE_BITS > FLOOR_W ? SAMPLE_BITS : FLOOR_W) + 2;
   localparam int DEN_W = 12;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [FLOOR_W-1:0]      floor_ff;
   logic [OFFSET_W-1:0]     offset_ff;
   logic [CHAN_W-1:0]       chan_ff;
   logic [NOTE_W-1:0]       note_ff;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]  held_ff, held_in;
   logic                    flag_ff, flag_in;
   logic [VEL_W-1:0]        vel_ff, vel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;
   logic                    div_start;

   logic signed [NUM_W-1:0] num;
   logic signed [DEN_W-1:0] den;
   logic [NUM_W-1:0]        thr;
   logic                    above, below, emit;
   logic [VEL_W-1:0]        pr;
   div_sts_type             div_sts;

   assign num = $signed(NUM_W'(sample_ff)) - $signed(NUM_W'(floor_ff))
              + $signed(NUM_W'(offset_ff));
   assign den = $signed(DEN_W'(FULL_SCALE)) - $signed(DEN_W'(floor_ff))
              + $signed(DEN_W'(offset_ff));
   assign thr   = NUM_W'(floor_ff) + NUM_W'(offset_ff);
   assign above = NUM_W'(sample_ff) > thr;
   assign below = NUM_W'(sample_ff) < thr;
   assign pr    = vel_ff[VEL_W-1] ? VEL_MAX : {vel_ff[VEL_W-2:0], 1'b0};

   tng_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_in (num[DIV_W-1:0]),
      .den_in (den[DIV_W-1:0]),
      .sts    (div_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff  <= FLOOR_RST;
         offset_ff <= OFFSET_RST;
         chan_ff   <= CHAN_RST;
         note_ff   <= NOTE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FLOOR:  floor_ff  <= csr_wdata[FLOOR_W-1:0];
            CSR_OFFSET: offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_CHAN:   chan_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_NOTE:   note_ff   <= csr_wdata[NOTE_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      held_in      = held_ff;
      flag_in      = flag_ff;
      vel_in       = vel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               state_in  = ST_CALC;
            end
         end
         ST_CALC: begin
            if (num <= 0) begin
               vel_in   = '0;
               state_in = ST_EMIT;
            end else if (den <= 0 || num >= NUM_W'(den)) begin
               vel_in   = VEL_MAX;
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               vel_in   = div_sts.quo;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (above && !flag_ff) begin
                  flag_in = 1'b1;
                  held_in = sample_ff;
               end
               if (below && flag_ff) begin
                  flag_in = 1'b0;
                  held_in = '0;
               end
               emit = flag_in && (held_in != sample_ff);
               if (emit) begin
                  held_in = sample_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_user_in  = emit;
               rsp_data_in  = '0;
               rsp_data_in[0] = flag_in;
               if (emit) begin
                  rsp_data_in[8:1]   = AT_STATUS | 8'(chan_ff);
                  rsp_data_in[15:9]  = note_ff;
                  rsp_data_in[22:16] = pr;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      vel_ff      <= vel_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ hdl/tng_chk.sv @@
module tng_chk #(
   parameter int SAMPLE_BITS = tng_pkg::SAMPLE_BITS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tng_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                              rsp_tuser
);
   import tng_pkg::*;

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while busy");

   // a waiting request keeps its sample
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting request changed");

   // no message means zero message fields
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_DATA_W-1:1] == '0)
      else $error("message fields set without aftertouch");

   // aftertouch only while the note is on, with status 0xA_
   a_msg_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[0] && rsp_tdata[8:5] == AT_STATUS[7:4])
      else $error("malformed aftertouch message");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind touch_note_gate_aftertouch tng_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_tng_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tng_pkg::*;

   localparam int SW    = SAMPLE_BITS_DEF;
   localparam int REQ_W = ((SW + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 16;

   typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_mode_type;

   // packed to match {rsp_tuser, rsp_tdata[22:0]}
   typedef struct packed {
      logic             aftertouch;
      logic [VEL_W-1:0] pressure;
      logic [6:0]       note;
      logic [7:0]       status;
      logic             active;
   } touch_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_FLOOR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   touch_note_gate_aftertouch #(.SAMPLE_BITS(SW)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // gate model state and register copies
   logic [FLOOR_W-1:0]  cfg_floor  = FLOOR_RST;
   logic [OFFSET_W-1:0] cfg_offset = OFFSET_RST;
   logic [CHAN_W-1:0]   cfg_chan   = CHAN_RST;
   logic [NOTE_W-1:0]   cfg_note   = NOTE_RST;
   logic                note_on    = 1'b0;
   logic [SW-1:0]       held_level = '0;

   touch_rsp_type touch_rsp_q[$];
   int         mismatch_count = 0;
   int         src_idle_pct = 0;
   int         snk_stall_pct = 0;
   int         hold_request = 0;
   int         hold_left = 0;
   int         last_sample = 0;

   function automatic int touch_velocity(logic [SW-1:0] s);
      int num, den;
      num = int'(s) - int'(cfg_floor) + int'(cfg_offset);
      den = FULL_SCALE - int'(cfg_floor) + int'(cfg_offset);
      if (num <= 0) return 0;
      if (den <= 0 || num >= den) return 127;
      return (127 * num) / den;
   endfunction

   task automatic predict_touch(input logic [SW-1:0] s);
      int thr, vel, dbl;
      touch_rsp_type r;
      thr = int'(cfg_floor) + int'(cfg_offset);
      vel = touch_velocity(s);
      r = '0;
      if (int'(s) > thr && !note_on) begin
         note_on = 1'b1;
         held_level = s;
      end
      if (int'(s) < thr && note_on) begin
         note_on = 1'b0;
         held_level = '0;
      end
      if (note_on && held_level != s) begin
         held_level = s;
         dbl = 2 * vel;
         r.aftertouch = 1'b1;
         r.status = AT_STATUS | 8'(cfg_chan);
         r.note = cfg_note;
         r.pressure = (dbl > 127) ? VEL_MAX : VEL_W'(dbl);
      end
      r.active = note_on;
      touch_rsp_q.push_back(r);
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : rsp_check
      touch_rsp_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tuser, rsp_tdata[22:0]};
         if (touch_rsp_q.size() == 0) begin
            note_mismatch($sformatf("%0t: unexpected transaction tdata=%h tuser=%b",
                                    $realtime, rsp_tdata, rsp_tuser));
         end else begin
            want = touch_rsp_q.pop_front();
            if (seen !== want)
               note_mismatch($sformatf(
                  "%0t: exp act=%b pv=%b st=%h nt=%0d pr=%0d got act=%b pv=%b st=%h nt=%0d pr=%0d",
                  $realtime, want.active, want.aftertouch, want.status, want.note,
                  want.pressure, seen.active, seen.aftertouch, seen.status, seen.note,
                  seen.pressure));
         end
      end
   end

   // receiver side, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   task automatic set_flow(input flow_mode_type m);
      case (m)
         FLOW_FREE: begin
            src_idle_pct = 0;
            snk_stall_pct = 0;
         end
         FLOW_SRC_IDLE: begin
            src_idle_pct = 71;
            snk_stall_pct = 0;
         end
         FLOW_SNK_STALL: begin
            src_idle_pct = 0;
            snk_stall_pct = 71;
         end
         default: begin
            src_idle_pct = 9;
            snk_stall_pct = 9;
         end
      endcase
   endtask

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_sample(input int s);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(SW'(s));
      do @(posedge clock); while (!req_tready);
      predict_touch(SW'(s));
      last_sample = s;
      @(negedge clock);
   endtask

   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (touch_rsp_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_controls(input int fl, input int ofs, input int ch, input int nt);
      csr_addr_type idx[4];
      int val[4];
      idx = '{CSR_FLOOR, CSR_OFFSET, CSR_CHAN, CSR_NOTE};
      val = '{fl, ofs, ch, nt};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= CSR_DATA_W'(val[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      cfg_floor = FLOOR_W'(fl);
      cfg_offset = OFFSET_W'(ofs);
      cfg_chan = CHAN_W'(ch);
      cfg_note = NOTE_W'(nt);
   endtask

   function automatic int clamp_sample(int v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v;
   endfunction

   function automatic int press_sample();
      int thr, roll;
      thr = int'(cfg_floor) + int'(cfg_offset);
      roll = $urandom_range(99);
      if (roll < 30) return last_sample;
      if (roll < 42) return clamp_sample(thr);
      if (roll < 50) return clamp_sample(thr + 1);
      return clamp_sample(thr + int'($urandom_range(400)));
   endfunction

   function automatic int idle_sample();
      int thr;
      thr = int'(cfg_floor) + int'(cfg_offset);
      return clamp_sample(thr - 1 - int'($urandom_range(60)));
   endfunction

   task automatic test_defaults();
      int seq[11];
      seq = '{0, 1023, 1023, 11, 10, 10, 9, 10, 0, 11, 0};
      foreach (seq[i]) send_sample(seq[i]);
   endtask

   task automatic test_register_extremes();
      int seq_zero[5];
      seq_zero = '{1, 2, 1014, 1023, 0};
      wait_for_quiet();
      write_controls(1023, 255, 15, 127);
      send_sample(0);
      send_sample(1023);
      wait_for_quiet();
      write_controls(0, 0, 0, 0);
      foreach (seq_zero[i]) send_sample(seq_zero[i]);
      // baseline above full scale: divisor not positive
      wait_for_quiet();
      write_controls(1020, 0, 9, 100);
      send_sample(1021);
      send_sample(1022);
      send_sample(1019);
      wait_for_quiet();
      write_controls(500, 0, 5, 33);
      send_sample(501);
      send_sample(500);
   endtask

   task automatic test_backpressure();
      wait_for_quiet();
      set_flow(FLOW_FREE);
      hold_request = 300;
      for (int i = 0; i < 16; i++) send_sample($urandom_range(1023));
   endtask

   task automatic random_controls();
      int roll, fl, ofs;
      roll = $urandom_range(99);
      if (roll < 60) begin
         fl = $urandom_range(600);
         ofs = $urandom_range(255);
      end else if (roll < 75) begin
         fl = $urandom_range(1023);
         ofs = $urandom_range(255);
      end else if (roll < 90) begin
         fl = $urandom_range(1023, 1000);
         ofs = $urandom_range(8);
      end else begin
         fl = 0;
         ofs = 0;
      end
      write_controls(fl, ofs, $urandom_range(15), $urandom_range(127));
   endtask

   task automatic test_random_touches(input flow_mode_type m, input int n_items);
      int sent, k;
      for (int c = 0; c < 4; c++) begin
         wait_for_quiet();
         random_controls();
         set_flow(m);
         sent = 0;
         while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
               send_sample($urandom_range(1023));
               sent++;
            end else begin
               k = $urandom_range(3);
               repeat (k) begin
                  send_sample(idle_sample());
                  sent++;
               end
               k = $urandom_range(15, 2);
               repeat (k) begin
                  send_sample(press_sample());
                  sent++;
               end
               send_sample(idle_sample());
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_flow(FLOW_FREE);
      test_defaults();
      test_register_extremes();
      test_backpressure();
      test_random_touches(FLOW_FREE, 120);
      test_random_touches(FLOW_SRC_IDLE, 120);
      test_random_touches(FLOW_SNK_STALL, 120);
      test_random_touches(FLOW_BOTH, 120);
      wait_for_quiet();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && touch_rsp_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
